[sv/cascaded_box_downsampler_unit_macros.svh]
// assertion macros for the downsampler rtl
`ifndef CASCADED_BOX_DOWNSAMPLER_UNIT_MACROS_SVH
`define CASCADED_BOX_DOWNSAMPLER_UNIT_MACROS_SVH

`ifndef SYNTH
`define CBDU_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("cbdu assertion failed");
`define CBDU_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("cbdu forbidden condition seen");
`else
`define CBDU_ASSERT(label, clk, rst, prop)
`define CBDU_NEVER(label, clk, rst, expr)
`endif

`endif

[sv/cbdu_pkg.sv]
// shared types and constants of the cascaded box downsampler
`timescale 1ns / 1ps
package cbdu_pkg;
   localparam int CHAN_W     = 8;
   localparam int NUM_CHAN   = 4;
   localparam int DIM_W      = 13;
   localparam int CNT_W      = 14;
   localparam int SUM_W      = 9;
   localparam int CHCNT_W    = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;
   localparam int MAX_WIDTH  = 4096;
   localparam int MAX_HEIGHT = 4096;
   localparam int MAX_LEVELS = 12;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH,
      CSR_IMAGE_HEIGHT,
      CSR_CHANNEL_COUNT,
      CSR_MAX_DIMENSION
   } csr_index_type;

   // one pixel moving between levels
   typedef struct packed {
      logic [NUM_CHAN-1:0][CHAN_W-1:0] chan;
      logic                            last;
   } pix_type;

   // per level geometry
   typedef struct packed {
      logic [DIM_W-1:0] in_w;
      logic [DIM_W-1:0] in_h;
      logic [DIM_W-1:0] out_w;
      logic [DIM_W-1:0] out_h;
      logic             active;
   } lvl_cfg_type;
endpackage

[sv/cbdu_ifs.sv]
// request and response channel interfaces
`timescale 1ns / 1ps
interface cbdu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] chan0;
   logic [7:0] chan1;
   logic [7:0] chan2;
   logic [7:0] chan3;
   modport source (output valid, chan0, chan1, chan2, chan3, input ready);
   modport sink (input valid, chan0, chan1, chan2, chan3, output ready);
endinterface

interface cbdu_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_chan0;
   logic [7:0]  out_chan1;
   logic [7:0]  out_chan2;
   logic [7:0]  out_chan3;
   logic [12:0] out_width;
   logic [12:0] out_height;
   logic        last_pixel;
   modport source (output valid, out_chan0, out_chan1, out_chan2, out_chan3,
                   out_width, out_height, last_pixel, input ready);
   modport sink (input valid, out_chan0, out_chan1, out_chan2, out_chan3,
                 out_width, out_height, last_pixel, output ready);
endinterface

[sv/cbdu_level.sv]
// one 2x2 halving level with its own line buffer of row pair sums
`timescale 1ns / 1ps
module cbdu_level #(
   parameter int MaxWidth   = cbdu_pkg::MAX_WIDTH,
   parameter int LevelIndex = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  logic                  restart,
   input  cbdu_pkg::lvl_cfg_type cfg,
   input  logic                  in_valid,
   input  cbdu_pkg::pix_type     in_pix,
   output logic                  in_last,
   output logic                  out_valid,
   output cbdu_pkg::pix_type     out_pix
);
   import cbdu_pkg::*;

   localparam int RawDepth = MaxWidth >> (LevelIndex + 1);
   localparam int AddrW    = (RawDepth > 2) ? $clog2(RawDepth) : 1;
   localparam int Depth    = 1 << AddrW;
   localparam int AvgW     = SUM_W + 1;

   logic [CNT_W-1:0] x_ff, x_in, y_ff, y_in;
   logic [CNT_W-1:0] x_next, y_next, hx_next, hy_next;
   logic             col_end, row_end;
   logic             accept, work, save_left, write_row, read_row, last_out;
   logic [AddrW-1:0] addr;
   logic [NUM_CHAN-1:0][CHAN_W-1:0] partial_ff;
   logic [NUM_CHAN-1:0][SUM_W-1:0]  pair, pair_ff, rd_ff;
   logic [NUM_CHAN-1:0][SUM_W-1:0]  mem [Depth];
   logic             valid_ff, last_ff;
   logic [AvgW-1:0]  avg_sum [NUM_CHAN];

   // position bookkeeping
   always_comb begin
      x_next  = x_ff + 1'b1;
      y_next  = y_ff + 1'b1;
      col_end = x_next >= {1'b0, cfg.in_w};
      row_end = y_next >= {1'b0, cfg.in_h};
      if (col_end) begin
         x_in = '0;
         y_in = row_end ? '0 : y_next;
      end else begin
         x_in = x_next;
         y_in = y_ff;
      end
      in_last  = (x_next == {1'b0, cfg.in_w}) && (y_next == {1'b0, cfg.in_h});
      hx_next  = {1'b0, x_ff[CNT_W-1:1]} + 1'b1;
      hy_next  = {1'b0, y_ff[CNT_W-1:1]} + 1'b1;
      last_out = (hx_next == {1'b0, cfg.out_w}) && (hy_next == {1'b0, cfg.out_h});
   end

   // what this beat does at this level
   always_comb begin
      accept    = in_valid && enable;
      work      = accept && cfg.active;
      save_left = work && !x_ff[0] && !col_end;
      write_row = work && x_ff[0] && !y_ff[0];
      read_row  = work && x_ff[0] && y_ff[0];
      addr      = x_ff[AddrW:1];
      for (int c = 0; c < NUM_CHAN; c++) begin
         pair[c] = {1'b0, in_pix.chan[c]} + {1'b0, partial_ff[c]};
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset || restart) begin
         x_ff <= '0;
         y_ff <= '0;
      end else if (accept) begin
         x_ff <= x_in;
         y_ff <= y_in;
      end
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= read_row;
      end
   end

   // line buffer and pair registers
   always_ff @(posedge clock) begin
      if (save_left) begin
         partial_ff <= in_pix.chan;
      end
      if (write_row) begin
         mem[addr] <= pair;
      end
      if (read_row) begin
         rd_ff   <= mem[addr];
         pair_ff <= pair;
         last_ff <= last_out;
      end
   end

   // finish the 2x2 average
   always_comb begin
      for (int c = 0; c < NUM_CHAN; c++) begin
         avg_sum[c]      = {1'b0, pair_ff[c]} + {1'b0, rd_ff[c]};
         out_pix.chan[c] = avg_sum[c][AvgW-1:2];
      end
      out_pix.last = last_ff;
      out_valid    = valid_ff;
   end
endmodule

[sv/cbdu_out_fifo.sv]
// two entry result queue that decouples the pipeline from the consumer
`timescale 1ns / 1ps
`include "cascaded_box_downsampler_unit_macros.svh"
module cbdu_out_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  cbdu_pkg::pix_type push_pix,
   output logic              space,
   input  logic              pop_ready,
   output logic              out_valid,
   output cbdu_pkg::pix_type out_pix
);
   import cbdu_pkg::*;

   localparam logic [1:0] FifoDepth = 2'd2;

   pix_type    entry_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       pop;

   always_comb begin
      space     = count_ff != FifoDepth;
      out_valid = count_ff != 2'd0;
      out_pix   = entry_ff[rd_ptr_ff];
      pop       = out_valid && pop_ready;
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_pix;
      end
   end

   `CBDU_NEVER(a_no_overflow, clock, reset, push && (count_ff == FifoDepth) && !pop)
   `CBDU_ASSERT(a_fill_up, clock, reset, (push && !pop) |=> (count_ff == $past(count_ff) + 2'd1))
   `CBDU_ASSERT(a_drain, clock, reset, (pop && !push) |=> (count_ff == $past(count_ff) - 2'd1))
endmodule

[sv/cascaded_box_downsampler_unit.sv]
// cascaded 2x2 box downsampler: one pixel per clock while the input is open, up to MaxLevels halvings
// throughput: one pixel accepted every cycle while the queue has space and no write settles
// each level has one line buffer port; input is held off while a register is written
// and until the settle counter has run down; each active halving adds an output register
// reset: synchronous, restores default registers and clears counters and queue
// line buffers are not cleared; odd rows only read entries the even row wrote
`timescale 1ns / 1ps
module cascaded_box_downsampler_unit #(
   parameter int MaxWidth  = cbdu_pkg::MAX_WIDTH,
   parameter int MaxLevels = cbdu_pkg::MAX_LEVELS
) (
   input  logic                              clock,
   input  logic                              reset,
   cbdu_req_if.sink                          req_bus,
   cbdu_rsp_if.source                        rsp_bus,
   input  logic                              csr_write_enable,
   input  logic [cbdu_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [cbdu_pkg::CSR_DATA_W-1:0]   csr_write_data
);
   import cbdu_pkg::*;

   logic [DIM_W-1:0]   width_ff, height_ff, maxdim_ff;
   logic [CHCNT_W-1:0] chcnt_ff;
   logic [DIM_W-1:0]   w_eff, h_eff, w_eff_ff, h_eff_ff;
   logic [CHCNT_W-1:0] ch_eff, ch_eff_ff;
   logic [MaxLevels-1:0] en, en_ff, final_sel, final_ff;
   logic               raw_sel_ff;
   logic [DIM_W-1:0]   out_w, out_h, out_w_ff, out_h_ff;
   logic [DIM_W-1:0]   wj, hj, mj;
   logic [1:0]         settle_ff;

   logic               space, in_open, accept, src_valid, push, fifo_valid;
   pix_type            in_pix, src_pix, fifo_pix;
   logic               lvl_in_valid [MaxLevels];
   pix_type            lvl_in_pix [MaxLevels];
   logic               lvl_out_valid [MaxLevels];
   pix_type            lvl_out_pix [MaxLevels];
   logic               lvl_in_last [MaxLevels];
   lvl_cfg_type        lvl_cfg [MaxLevels];

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_W'(1);
         height_ff <= DIM_W'(1);
         chcnt_ff  <= CHCNT_W'(4);
         maxdim_ff <= DIM_W'(256);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:   width_ff  <= csr_write_data;
            CSR_IMAGE_HEIGHT:  height_ff <= csr_write_data;
            CSR_CHANNEL_COUNT: chcnt_ff  <= csr_write_data[CHCNT_W-1:0];
            CSR_MAX_DIMENSION: maxdim_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // hold the input off until the derived level setup has settled
   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= 2'd0;
      end else if (csr_write_enable) begin
         settle_ff <= 2'd2;
      end else if (settle_ff != 2'd0) begin
         settle_ff <= settle_ff - 2'd1;
      end
   end

   // clamp sizes and find which halvings run
   always_comb begin
      if (width_ff == '0) w_eff = DIM_W'(1);
      else if (int'(width_ff) > MaxWidth) w_eff = DIM_W'(MaxWidth);
      else w_eff = width_ff;
      if (height_ff == '0) h_eff = DIM_W'(1);
      else if (int'(height_ff) > MAX_HEIGHT) h_eff = DIM_W'(MAX_HEIGHT);
      else h_eff = height_ff;
      if (chcnt_ff == '0) ch_eff = CHCNT_W'(1);
      else if (chcnt_ff > CHCNT_W'(NUM_CHAN)) ch_eff = CHCNT_W'(NUM_CHAN);
      else ch_eff = chcnt_ff;
      wj = '0;
      hj = '0;
      mj = '0;
      for (int j = 0; j < MaxLevels; j++) begin
         wj    = w_eff >> j;
         hj    = h_eff >> j;
         mj    = (wj > hj) ? wj : hj;
         en[j] = (mj > maxdim_ff) && (wj > DIM_W'(1)) && (hj > DIM_W'(1));
      end
   end

   // final level and final size
   always_comb begin
      out_w = w_eff_ff;
      out_h = h_eff_ff;
      for (int j = 0; j < MaxLevels; j++) begin
         if (j == MaxLevels - 1) final_sel[j] = en_ff[j];
         else final_sel[j] = en_ff[j] && !en_ff[j+1];
         if (en_ff[j]) begin
            out_w = w_eff_ff >> (j + 1);
            out_h = h_eff_ff >> (j + 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_eff_ff   <= DIM_W'(1);
         h_eff_ff   <= DIM_W'(1);
         ch_eff_ff  <= CHCNT_W'(NUM_CHAN);
         en_ff      <= '0;
         final_ff   <= '0;
         raw_sel_ff <= 1'b1;
         out_w_ff   <= DIM_W'(1);
         out_h_ff   <= DIM_W'(1);
      end else begin
         w_eff_ff   <= w_eff;
         h_eff_ff   <= h_eff;
         ch_eff_ff  <= ch_eff;
         en_ff      <= en;
         final_ff   <= final_sel;
         raw_sel_ff <= !en_ff[0];
         out_w_ff   <= out_w;
         out_h_ff   <= out_h;
      end
   end

   // input beat with unused channels forced to zero
   always_comb begin
      in_open        = space && !csr_write_enable && (settle_ff == 2'd0);
      accept         = req_bus.valid && in_open;
      req_bus.ready  = in_open;
      in_pix.chan[0] = req_bus.chan0;
      in_pix.chan[1] = (ch_eff_ff > CHCNT_W'(1)) ? req_bus.chan1 : '0;
      in_pix.chan[2] = (ch_eff_ff > CHCNT_W'(2)) ? req_bus.chan2 : '0;
      in_pix.chan[3] = (ch_eff_ff > CHCNT_W'(3)) ? req_bus.chan3 : '0;
      in_pix.last    = 1'b0;
   end

   // chain of halving levels
   for (genvar j = 0; j < MaxLevels; j++) begin : g_level
      if (j == 0) begin : g_first
         assign lvl_in_valid[j] = accept;
         assign lvl_in_pix[j]   = in_pix;
      end else begin : g_later
         assign lvl_in_valid[j] = lvl_out_valid[j-1];
         assign lvl_in_pix[j]   = lvl_out_pix[j-1];
      end
      assign lvl_cfg[j].in_w   = w_eff_ff >> j;
      assign lvl_cfg[j].in_h   = h_eff_ff >> j;
      assign lvl_cfg[j].out_w  = w_eff_ff >> (j + 1);
      assign lvl_cfg[j].out_h  = h_eff_ff >> (j + 1);
      assign lvl_cfg[j].active = en_ff[j];

      cbdu_level #(
         .MaxWidth   (MaxWidth),
         .LevelIndex (j)
      ) u_level (
         .clock     (clock),
         .reset     (reset),
         .enable    (space),
         .restart   (csr_write_enable),
         .cfg       (lvl_cfg[j]),
         .in_valid  (lvl_in_valid[j]),
         .in_pix    (lvl_in_pix[j]),
         .in_last   (lvl_in_last[j]),
         .out_valid (lvl_out_valid[j]),
         .out_pix   (lvl_out_pix[j])
      );
   end

   // pick the stream of the last active level, or the raw input when none is active
   always_comb begin
      src_valid      = 1'b0;
      src_pix        = in_pix;
      src_pix.last   = lvl_in_last[0];
      if (raw_sel_ff) begin
         src_valid = accept;
      end
      for (int j = 0; j < MaxLevels; j++) begin
         if (final_ff[j]) begin
            src_valid = lvl_out_valid[j];
            src_pix   = lvl_out_pix[j];
         end
      end
      push = src_valid && space;
   end

   cbdu_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_pix  (src_pix),
      .space     (space),
      .pop_ready (rsp_bus.ready),
      .out_valid (fifo_valid),
      .out_pix   (fifo_pix)
   );

   // result beat
   always_comb begin
      rsp_bus.valid      = fifo_valid;
      rsp_bus.out_chan0  = fifo_pix.chan[0];
      rsp_bus.out_chan1  = fifo_pix.chan[1];
      rsp_bus.out_chan2  = fifo_pix.chan[2];
      rsp_bus.out_chan3  = fifo_pix.chan[3];
      rsp_bus.last_pixel = fifo_pix.last;
      rsp_bus.out_width  = out_w_ff;
      rsp_bus.out_height = out_h_ff;
   end
endmodule
